[src/lcdrs_pkg.sv]
// Shared types and constants for the character LCD refresh sequencer.
`default_nettype none

package lcdrs_pkg;

   // Input command codes.
   localparam logic [1:0] CMD_STORE = 2'd0;
   localparam logic [1:0] CMD_START = 2'd1;
   localparam logic [1:0] CMD_TICK  = 2'd2;

   // Result kinds on the display bus.
   localparam logic [1:0] KIND_COMMAND  = 2'd0;
   localparam logic [1:0] KIND_DATA     = 2'd1;
   localparam logic [1:0] KIND_FINISHED = 2'd2;

   localparam logic [7:0] CHAR_SPACE      = 8'h20;
   localparam logic [7:0] CHAR_NONE       = 8'h00;
   localparam logic [7:0] CMD_SET_ADDR    = 8'h80;
   localparam logic [7:0] LINE_TWO_OFFSET = 8'h40;
   localparam logic [7:0] CMD_LINE_ONE    = CMD_SET_ADDR;
   localparam logic [7:0] CMD_LINE_TWO    = CMD_SET_ADDR | LINE_TWO_OFFSET;

   typedef struct packed {
      logic [1:0] cmd;
      logic       row_index;
      logic [3:0] column_index;
      logic [7:0] char_code;
      logic       display_busy;
   } req_type;

   typedef struct packed {
      logic [1:0] bus_kind;
      logic [7:0] bus_data;
   } rsp_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic       store;
      logic       read;
      logic       pad_write;
      logic       cursor_clear;
      logic       col_step;
      logic       row_step;
      logic       out_valid;
      logic       out_use_ram;
      logic [1:0] out_kind;
      logic [7:0] out_byte;
   } dp_cmd_type;

   // Cursor status from the datapath to the controller.
   typedef struct packed {
      logic rows_done;
      logic row_end;
      logic pad_row_end;
      logic pad_done;
   } dp_status_type;

endpackage

`default_nettype wire

[src/char_lcd_refresh_sequencer_core.sv]
// Character LCD refresh sequencer: top level joining controller and datapath.
// Stores, ignored items and ticks that emit a command or the finished marker leave busy low;
// any result they cause shows in the next cycle.
// A tick that sends a character first reads the buffer RAM, whose read data is registered, then
// emits the character from ST_TICK_OUT through the result register.
// A start takes the transfer, then a read and a write per entry (ST_PAD_RD, then ST_PAD_WR).
// Its 0x80 command shows in the first cycle with busy low; results cannot be stalled.
// Synchronous reset clears the buffer's valid bits, cursor and refresh state at once.
`default_nettype none

module char_lcd_refresh_sequencer_core #(
   parameter int ROWS    = 2,
   parameter int COLUMNS = 16
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output      logic               busy,
   input  wire lcdrs_pkg::req_type req_item,
   output      logic               rsp_strobe,
   output      lcdrs_pkg::rsp_type rsp_item
);

   import lcdrs_pkg::*;

   dp_cmd_type    dp_cmd;
   dp_status_type dp_status;

   lcdrs_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req_item  (req_item),
      .dp_status (dp_status),
      .busy      (busy),
      .dp_cmd    (dp_cmd)
   );

   lcdrs_datapath #(
      .ROWS    (ROWS),
      .COLUMNS (COLUMNS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_item   (req_item),
      .dp_cmd     (dp_cmd),
      .dp_status  (dp_status),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item)
   );

endmodule

`default_nettype wire

[src/lcdrs_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module lcdrs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  wire logic                                    clock,
   input  wire logic                                    wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                        wr_data,
   input  wire logic                                    rd_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output      logic [WIDTH-1:0]                        rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[src/lcdrs_datapath.sv]
// Datapath: character buffer, cursor counters, padding flag and result register.
`default_nettype none

module lcdrs_datapath #(
   parameter int ROWS    = 2,
   parameter int COLUMNS = 16
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire lcdrs_pkg::req_type    req_item,
   input  wire lcdrs_pkg::dp_cmd_type dp_cmd,
   output      lcdrs_pkg::dp_status_type dp_status,
   output      logic                  rsp_strobe,
   output      lcdrs_pkg::rsp_type    rsp_item
);

   import lcdrs_pkg::*;

   localparam int DEPTH  = ROWS * COLUMNS;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int ROW_W  = $clog2(ROWS + 1);
   localparam int COL_W  = $clog2(COLUMNS + 1);

   logic [ROW_W-1:0]  row_ff, row_in;
   logic [COL_W-1:0]  col_ff, col_in;
   logic              ended_ff, ended_in;
   logic [DEPTH-1:0]  valid_ff, valid_in;
   logic              rd_valid_ff, rd_valid_in;
   logic              rsp_strobe_ff, rsp_strobe_in;
   rsp_type           rsp_ff, rsp_in;

   logic [ADDR_W-1:0] cursor_addr;
   logic [ADDR_W-1:0] store_addr;
   logic              store_ok;
   logic [7:0]        ram_q;
   logic [7:0]        rd_byte;
   logic              ended_now;
   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [7:0]        wr_data;

   assign cursor_addr = ADDR_W'(int'(row_ff) * COLUMNS + int'(col_ff));
   assign store_addr  = ADDR_W'(int'(req_item.row_index) * COLUMNS
                                + int'(req_item.column_index));
   assign store_ok    = dp_cmd.store && (int'(req_item.row_index) < ROWS)
                        && (int'(req_item.column_index) < COLUMNS);

   // Entries never written since reset read as zero.
   assign rd_byte   = rd_valid_ff ? ram_q : CHAR_NONE;
   assign ended_now = ended_ff || (rd_byte == CHAR_NONE);

   assign wr_en   = store_ok || (dp_cmd.pad_write && ended_now);
   assign wr_addr = dp_cmd.pad_write ? cursor_addr : store_addr;
   assign wr_data = dp_cmd.pad_write ? CHAR_SPACE : req_item.char_code;

   lcdrs_ram #(
      .WIDTH (8),
      .DEPTH (DEPTH)
   ) u_buffer (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (dp_cmd.read),
      .rd_addr (cursor_addr),
      .rd_data (ram_q)
   );

   always_comb begin
      valid_in = valid_ff;
      if (wr_en) begin
         valid_in[wr_addr] = 1'b1;
      end
      rd_valid_in = dp_cmd.read ? valid_ff[cursor_addr] : rd_valid_ff;

      row_in = row_ff;
      col_in = col_ff;
      if (dp_cmd.cursor_clear) begin
         row_in = '0;
         col_in = '0;
      end else if (dp_cmd.row_step) begin
         row_in = row_ff + ROW_W'(1);
         col_in = '0;
      end else if (dp_cmd.col_step) begin
         col_in = col_ff + COL_W'(1);
      end

      ended_in = ended_ff;
      if (dp_cmd.pad_write) begin
         ended_in = ended_now;
      end
      if (dp_cmd.cursor_clear || dp_cmd.row_step) begin
         ended_in = 1'b0;
      end

      rsp_strobe_in = dp_cmd.out_valid;
      rsp_in        = rsp_ff;
      if (dp_cmd.out_valid) begin
         rsp_in.bus_kind = dp_cmd.out_kind;
         rsp_in.bus_data = dp_cmd.out_use_ram ? rd_byte : dp_cmd.out_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff        <= '0;
         col_ff        <= '0;
         ended_ff      <= 1'b0;
         valid_ff      <= '0;
         rd_valid_ff   <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         row_ff        <= row_in;
         col_ff        <= col_in;
         ended_ff      <= ended_in;
         valid_ff      <= valid_in;
         rd_valid_ff   <= rd_valid_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
      rsp_ff <= rsp_in;
   end

   assign dp_status.rows_done   = (row_ff >= ROW_W'(ROWS));
   assign dp_status.row_end     = (col_ff >= COL_W'(COLUMNS));
   assign dp_status.pad_row_end = (col_ff == COL_W'(COLUMNS - 1));
   assign dp_status.pad_done    = (col_ff == COL_W'(COLUMNS - 1))
                                  && (row_ff == ROW_W'(ROWS - 1));

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_ff;

endmodule

`default_nettype wire

[src/lcdrs_controller.sv]
// Controller: command decode, padding walk sequencing and refresh state.
`default_nettype none

module lcdrs_controller (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     start,
   input  wire lcdrs_pkg::req_type       req_item,
   input  wire lcdrs_pkg::dp_status_type dp_status,
   output      logic                     busy,
   output      lcdrs_pkg::dp_cmd_type    dp_cmd
);

   import lcdrs_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE     = 4'b0001,
      ST_PAD_RD   = 4'b0010,
      ST_PAD_WR   = 4'b0100,
      ST_TICK_OUT = 4'b1000
   } state_type;

   state_type state_ff, state_in;
   logic      active_ff, active_in;
   logic      accept;

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;

   always_comb begin
      state_in  = state_ff;
      active_in = active_ff;
      dp_cmd    = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (req_item.cmd)
                  CMD_STORE: begin
                     dp_cmd.store = 1'b1;
                  end
                  CMD_START: begin
                     if (!active_ff) begin
                        dp_cmd.cursor_clear = 1'b1;
                        state_in            = ST_PAD_RD;
                     end
                  end
                  CMD_TICK: begin
                     if (active_ff && !req_item.display_busy) begin
                        if (dp_status.rows_done) begin
                           dp_cmd.out_valid = 1'b1;
                           dp_cmd.out_kind  = KIND_FINISHED;
                           dp_cmd.out_byte  = CHAR_NONE;
                           active_in        = 1'b0;
                        end else if (dp_status.row_end) begin
                           dp_cmd.out_valid = 1'b1;
                           dp_cmd.out_kind  = KIND_COMMAND;
                           dp_cmd.out_byte  = CMD_LINE_TWO;
                           dp_cmd.row_step  = 1'b1;
                        end else begin
                           dp_cmd.read = 1'b1;
                           state_in    = ST_TICK_OUT;
                        end
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_PAD_RD: begin
            dp_cmd.read = 1'b1;
            state_in    = ST_PAD_WR;
         end
         ST_PAD_WR: begin
            dp_cmd.pad_write = 1'b1;
            if (dp_status.pad_done) begin
               // Last entry padded: the refresh opens with the first line address.
               dp_cmd.cursor_clear = 1'b1;
               dp_cmd.out_valid    = 1'b1;
               dp_cmd.out_kind     = KIND_COMMAND;
               dp_cmd.out_byte     = CMD_LINE_ONE;
               active_in           = 1'b1;
               state_in            = ST_IDLE;
            end else begin
               if (dp_status.pad_row_end) begin
                  dp_cmd.row_step = 1'b1;
               end else begin
                  dp_cmd.col_step = 1'b1;
               end
               state_in = ST_PAD_RD;
            end
         end
         ST_TICK_OUT: begin
            dp_cmd.out_valid   = 1'b1;
            dp_cmd.out_kind    = KIND_DATA;
            dp_cmd.out_use_ram = 1'b1;
            dp_cmd.col_step    = 1'b1;
            state_in           = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         active_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         active_ff <= active_in;
      end
   end

endmodule

`default_nettype wire

[src/lcdrs_checker.sv]
// Port-level checks for the refresh sequencer, bound to the top level.
`default_nettype none

module lcdrs_checker (
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               start,
   input wire logic               busy,
   input wire lcdrs_pkg::req_type req_item,
   input wire logic               rsp_strobe,
   input wire lcdrs_pkg::rsp_type rsp_item
);

   import lcdrs_pkg::*;

   // A stored character never produces a bus transfer.
   a_store_silent: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_item.cmd == CMD_STORE) |=> !rsp_strobe)
      else $error("store item produced a result");

   // A tick that finds the display busy produces nothing.
   a_busy_tick_silent: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_item.cmd == CMD_TICK && req_item.display_busy)
      |=> !rsp_strobe)
      else $error("busy tick produced a result");

   // Every result follows an accepted item or internal work.
   a_result_has_cause: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> ($past(start && !busy) || $past(busy)))
      else $error("result appeared without a cause");

   // The finished marker carries a zero byte.
   a_finished_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_item.bus_kind == KIND_FINISHED) |-> (rsp_item.bus_data == 8'h00))
      else $error("finished marker with nonzero data");

endmodule

bind char_lcd_refresh_sequencer_core lcdrs_checker u_checker (.*);

`default_nettype wire
